// ===== hw/rtl/scalar_field_mod_alu_macros.svh =====
// ----------------------------------------------------------------------------
// scalar field alu assertion macros
// shared concurrent assertion forms, sampled on the clock, off during reset
// ----------------------------------------------------------------------------
`ifndef SCALAR_FIELD_MOD_ALU_MACROS_SVH
`define SCALAR_FIELD_MOD_ALU_MACROS_SVH

// same-cycle implication
`define SFMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfma assertion failed");

// next-cycle implication
`define SFMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfma assertion failed");

`endif

// ===== hw/rtl/sfma_pkg.sv =====
// ----------------------------------------------------------------------------
// sfma_pkg
// types and constants of the scalar field modular alu
// ----------------------------------------------------------------------------
`default_nettype none

package sfma_pkg;

  localparam int unsigned FW = 256;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2
  } func_e;

  // group order r and the 64-bit montgomery constant -r^-1 mod 2^64
  localparam logic [FW-1:0] R_MOD =
    256'h73eda753299d7d48_3339d80809a1d805_53bda402fffe5bfe_ffffffff00000001;
  localparam logic [63:0] MONT_N0 = 64'hfffffffeffffffff;

  // -r^-1 mod 2^256, lifted from the 64-bit constant by newton steps
  function automatic logic [FW-1:0] calc_nprime();
    logic [FW-1:0] inv;
    inv = {192'd0, 64'(-MONT_N0)};
    for (int k = 0; k < 3; k++) begin
      inv = inv * (256'd2 - R_MOD * inv);
    end
    return -inv;
  endfunction

  localparam logic [FW-1:0] NPRIME = calc_nprime();

  // sideband carried along the pipeline
  typedef struct packed {
    logic [1:0]    func;
    logic          flag;
    logic [FW-1:0] aux;
    logic [FW-1:0] phi;
    logic          nz;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfma_if.sv =====
// ----------------------------------------------------------------------------
// sfma_if
// request and result channels of the scalar field alu
// ----------------------------------------------------------------------------
`default_nettype none

interface sfma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] a_limb0;
  logic [63:0] a_limb1;
  logic [63:0] a_limb2;
  logic [63:0] a_limb3;
  logic [63:0] b_limb0;
  logic [63:0] b_limb1;
  logic [63:0] b_limb2;
  logic [63:0] b_limb3;

  modport source (
    output valid, func, a_limb0, a_limb1, a_limb2, a_limb3,
           b_limb0, b_limb1, b_limb2, b_limb3,
    input  ready
  );
  modport sink (
    input  valid, func, a_limb0, a_limb1, a_limb2, a_limb3,
           b_limb0, b_limb1, b_limb2, b_limb3,
    output ready
  );
endinterface

interface sfma_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_limb0;
  logic [63:0] res_limb1;
  logic [63:0] res_limb2;
  logic [63:0] res_limb3;

  modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3, input ready);
  modport sink (input valid, res_limb0, res_limb1, res_limb2, res_limb3, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scalar_field_mod_alu.sv =====
// throughput: one request per cycle while results are taken, set by the fully pipelined
//   32x32 product arrays and adder trees of the three chained 256-bit multipliers
// each stage holds its item under back-pressure and bubbles close up
// reset clears the stage valid bits only; datapath registers are not reset
// ----------------------------------------------------------------------------
// scalar_field_mod_alu
// modular add, subtract and montgomery multiply over the bls12-381 order r
// ----------------------------------------------------------------------------
`default_nettype none

`include "scalar_field_mod_alu_macros.svh"

module scalar_field_mod_alu (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sfma_in_if.sink    req_i,
  sfma_out_if.source res_o
);

  localparam int unsigned FW = sfma_pkg::FW;
  localparam int unsigned NS = 17;
  localparam int unsigned NSIDE = 16;

  logic [NS:1]         v_q;
  logic [NS+1:1]       en;
  sfma_pkg::side_t     side_q [NSIDE:1];
  sfma_pkg::side_t     side_d [NSIDE:1];
  logic [FW-1:0]       res_q;
  logic [FW-1:0]       res_d;
  logic [FW-1:0]       op_a;
  logic [FW-1:0]       op_b;
  logic [2*FW-1:0]     pa;
  logic [FW-1:0]       pm;
  logic [2*FW-1:0]     pq;

  assign op_a = {req_i.a_limb3, req_i.a_limb2, req_i.a_limb1, req_i.a_limb0};
  assign op_b = {req_i.b_limb3, req_i.b_limb2, req_i.b_limb1, req_i.b_limb0};

  // per-stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    en[NS+1] = res_o.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= req_i.valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // p = a*b, m = p_low * (-r^-1), q = m*r
  sfma_mul256 #(.PW(2*FW)) u_mul_ab (
    .clk_i (clk_i), .en_i (en[5:1]), .x_i (op_a), .y_i (op_b), .p_o (pa)
  );

  sfma_mul256 #(.PW(FW)) u_mul_m (
    .clk_i (clk_i), .en_i (en[10:6]), .x_i (pa[FW-1:0]), .y_i (sfma_pkg::NPRIME), .p_o (pm)
  );

  sfma_mul256 #(.PW(2*FW)) u_mul_q (
    .clk_i (clk_i), .en_i (en[15:11]), .x_i (pm), .y_i (sfma_pkg::R_MOD), .p_o (pq)
  );

  // sideband next values
  always_comb begin
    logic [FW:0]   sum;
    logic [FW:0]   dif;
    logic [FW:0]   dr;
    logic [FW:0]   tt;
    logic [FW+1:0] dt;

    // stage 1: raw sum or difference with carry / borrow
    sum = {1'b0, op_a} + {1'b0, op_b};
    dif = {1'b0, op_a} - {1'b0, op_b};
    side_d[1] = '0;
    side_d[1].func = req_i.func;
    if (req_i.func == sfma_pkg::FUNC_SUB) begin
      side_d[1].aux  = dif[FW-1:0];
      side_d[1].flag = dif[FW];
    end else begin
      side_d[1].aux  = sum[FW-1:0];
      side_d[1].flag = sum[FW];
    end

    for (int k = 2; k <= NSIDE; k++) begin
      side_d[k] = side_q[k-1];
    end

    // stage 2: reduce the sum or add r back on borrow
    dr = {1'b0, side_q[1].aux} - {1'b0, sfma_pkg::R_MOD};
    if (side_q[1].func == sfma_pkg::FUNC_SUB) begin
      if (side_q[1].flag) side_d[2].aux = side_q[1].aux + sfma_pkg::R_MOD;
    end else begin
      if (side_q[1].flag || !dr[FW]) side_d[2].aux = dr[FW-1:0];
    end

    // stage 6: keep the high product half and whether the low half is nonzero
    side_d[6].phi = pa[2*FW-1:FW];
    side_d[6].nz  = |pa[FW-1:0];

    // stage 16: t = (p + q) / 2^256, low halves cancel to zero or one carry
    tt = {1'b0, side_q[15].phi} + {1'b0, pq[2*FW-1:FW]} + {{FW{1'b0}}, side_q[15].nz};
    side_d[16].phi  = tt[FW-1:0];
    side_d[16].flag = tt[FW];

    // stage 17: final conditional subtraction and operation select
    dt = {1'b0, side_q[16].flag, side_q[16].phi} - {2'b00, sfma_pkg::R_MOD};
    unique case (side_q[16].func)
      sfma_pkg::FUNC_ADD,
      sfma_pkg::FUNC_SUB: res_d = side_q[16].aux;
      sfma_pkg::FUNC_MUL: res_d = dt[FW+1] ? side_q[16].phi : dt[FW-1:0];
      default:            res_d = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NSIDE; k++) begin
      if (en[k]) side_q[k] <= side_d[k];
    end
    if (en[NS]) res_q <= res_d;
  end

  assign res_o.valid     = v_q[NS];
  assign res_o.res_limb0 = res_q[63:0];
  assign res_o.res_limb1 = res_q[127:64];
  assign res_o.res_limb2 = res_q[191:128];
  assign res_o.res_limb3 = res_q[255:192];

  // a stall can only start at a held result
  `SFMA_ASSERT_NOW(a_stall_from_out, clk_i, rst_ni, !en[1], v_q[NS] && !res_o.ready)
  // an accepted request is in the first stage in the next cycle
  `SFMA_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, req_i.valid && en[1], v_q[1])
  // stage 8, when full with a stalled successor, keeps its item
  `SFMA_ASSERT_NEXT(a_mid_hold, clk_i, rst_ni, v_q[8] && !en[9], v_q[8])

endmodule

`default_nettype wire

// ===== hw/rtl/sfma_mul256.sv =====
// ----------------------------------------------------------------------------
// sfma_mul256
// five-stage 256x256 multiplier: 32x32 partial products, then adder tree
// ----------------------------------------------------------------------------
`default_nettype none

module sfma_mul256 #(
  parameter int unsigned PW = 512
) (
  input  wire logic                    clk_i,
  input  wire logic [4:0]              en_i,
  input  wire logic [sfma_pkg::FW-1:0] x_i,
  input  wire logic [sfma_pkg::FW-1:0] y_i,
  output logic      [PW-1:0]           p_o
);

  localparam int unsigned DW = 32;
  localparam int unsigned ND = sfma_pkg::FW / DW;

  logic [2*DW-1:0] pp_q [ND][ND];
  logic [PW-1:0]   vec  [2*ND];
  logic [PW-1:0]   s1_q [ND];
  logic [PW-1:0]   s2_q [ND/2];
  logic [PW-1:0]   s3_q [ND/4];
  logic [PW-1:0]   p_q;

  // partial products, only those that land below the product width
  for (genvar i = 0; i < ND; i++) begin : g_row
    for (genvar j = 0; j < ND; j++) begin : g_col
      if (DW * (i + j) < PW) begin : g_pp
        always_ff @(posedge clk_i) begin
          if (en_i[0]) begin
            pp_q[i][j] <= {{DW{1'b0}}, x_i[DW*i +: DW]} * {{DW{1'b0}}, y_i[DW*j +: DW]};
          end
        end
      end
    end
  end

  // even and odd columns of each row do not overlap: pack them
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      for (int e = 0; e < 2; e++) begin
        vec[2*i+e] = '0;
        for (int j = e; j < ND; j += 2) begin
          if (DW * (i + j) < PW) begin
            vec[2*i+e] = vec[2*i+e] | (PW'(pp_q[i][j]) << (DW * (i + j)));
          end
        end
      end
    end
  end

  // adder tree, one level per stage
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int n = 0; n < ND; n++) s1_q[n] <= vec[2*n] + vec[2*n+1];
    end
    if (en_i[2]) begin
      for (int n = 0; n < ND/2; n++) s2_q[n] <= s1_q[2*n] + s1_q[2*n+1];
    end
    if (en_i[3]) begin
      for (int n = 0; n < ND/4; n++) s3_q[n] <= s2_q[2*n] + s2_q[2*n+1];
    end
    if (en_i[4]) begin
      p_q <= s3_q[0] + s3_q[1];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks modular add, subtract and montgomery multiply over the group order:
// a driver feeds requests from a queue, a monitor compares every result with
// a predicted value under random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned LATENCY    = 17;

  typedef struct packed {
    logic [1:0]    func;
    logic [255:0]  a;
    logic [255:0]  b;
  } req_t;

  logic clk_i;
  logic rst_ni;

  sfma_in_if  req_if ();
  sfma_out_if res_if ();

  scalar_field_mod_alu uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  req_t           pending_q[$];
  logic [255:0]   expected_q[$];
  int             err_cnt;
  int unsigned    cycle_cnt;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_off_cnt;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // modular add with one conditional subtraction
  function automatic logic [255:0] fr_add(logic [255:0] a, logic [255:0] b);
    logic [256:0] s;
    logic [256:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, sfma_pkg::R_MOD};
    return (s >= {1'b0, sfma_pkg::R_MOD}) ? d[255:0] : s[255:0];
  endfunction

  // modular subtract, add back on borrow
  function automatic logic [255:0] fr_sub(logic [255:0] a, logic [255:0] b);
    logic [255:0] d;
    d = a - b;
    return (a < b) ? d + sfma_pkg::R_MOD : d;
  endfunction

  // montgomery product, word-serial with 64-bit digits
  function automatic logic [255:0] fr_mont_mul(logic [255:0] a, logic [255:0] b);
    logic [321:0] t;
    logic [63:0]  m;
    logic [321:0] d;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t = t + 322'(a) * 322'(b[64*i +: 64]);
      m = t[63:0] * sfma_pkg::MONT_N0;
      t = (t + 322'(m) * 322'(sfma_pkg::R_MOD)) >> 64;
    end
    t = {65'd0, t[256:0]};
    d = t - 322'(sfma_pkg::R_MOD);
    return (t >= 322'(sfma_pkg::R_MOD)) ? d[255:0] : t[255:0];
  endfunction

  function automatic logic [255:0] fr_result(req_t r);
    case (r.func)
      sfma_pkg::FUNC_ADD: return fr_add(r.a, r.b);
      sfma_pkg::FUNC_SUB: return fr_sub(r.a, r.b);
      sfma_pkg::FUNC_MUL: return fr_mont_mul(r.a, r.b);
      default:            return '0;
    endcase
  endfunction

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  // operand mostly reduced, sometimes near r, tiny or any value
  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    int unsigned  sel;
    sel = $urandom_range(0, 99);
    v = rand_wide();
    if (sel < 10) v = sfma_pkg::R_MOD - 256'($urandom_range(1, 4));
    else if (sel < 15) v = 256'($urandom_range(0, 3));
    else if (sel < 25) v = v;
    else v = v % sfma_pkg::R_MOD;
    return v;
  endfunction

  task automatic push_req(logic [1:0] f, logic [255:0] a, logic [255:0] b);
    req_t r;
    r.func = f;
    r.a    = a;
    r.b    = b;
    pending_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_t r;
          r = pending_q.pop_front();
          expected_q.push_back(fr_result(r));
          req_if.valid   <= 1'b1;
          req_if.func    <= r.func;
          req_if.a_limb0 <= r.a[63:0];
          req_if.a_limb1 <= r.a[127:64];
          req_if.a_limb2 <= r.a[191:128];
          req_if.a_limb3 <= r.a[255:192];
          req_if.b_limb0 <= r.b[63:0];
          req_if.b_limb1 <= r.b[127:64];
          req_if.b_limb2 <= r.b[191:128];
          req_if.b_limb3 <= r.b[255:192];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_off_cnt > 0) begin
      hold_off_cnt <= hold_off_cnt - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", res_if.res_limb0, '0);
      end else begin
        logic [255:0] e;
        e = expected_q.pop_front();
        if (res_if.res_limb0 !== e[63:0])
          report_mismatch("res_limb0", res_if.res_limb0, e[63:0]);
        if (res_if.res_limb1 !== e[127:64])
          report_mismatch("res_limb1", res_if.res_limb1, e[127:64]);
        if (res_if.res_limb2 !== e[191:128])
          report_mismatch("res_limb2", res_if.res_limb2, e[191:128]);
        if (res_if.res_limb3 !== e[255:192])
          report_mismatch("res_limb3", res_if.res_limb3, e[255:192]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
  endtask

  // stimulus phases
  initial begin
    logic [255:0] all_ones;
    all_ones       = '1;
    err_cnt        = 0;
    cycle_cnt      = 0;
    hold_off_cnt   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = sfma_pkg::FUNC_ADD;
    req_if.a_limb0 = '0; req_if.a_limb1 = '0; req_if.a_limb2 = '0; req_if.a_limb3 = '0;
    req_if.b_limb0 = '0; req_if.b_limb1 = '0; req_if.b_limb2 = '0; req_if.b_limb3 = '0;
    res_if.ready   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every operation, unused code, unreduced operands
    push_req(sfma_pkg::FUNC_ADD, '0, '0);
    push_req(sfma_pkg::FUNC_ADD, sfma_pkg::R_MOD - 1, sfma_pkg::R_MOD - 1);
    push_req(sfma_pkg::FUNC_ADD, sfma_pkg::R_MOD - 1, 256'd1);
    push_req(sfma_pkg::FUNC_ADD, all_ones, all_ones);
    push_req(sfma_pkg::FUNC_ADD, sfma_pkg::R_MOD, '0);
    push_req(sfma_pkg::FUNC_SUB, '0, '0);
    push_req(sfma_pkg::FUNC_SUB, '0, 256'd1);
    push_req(sfma_pkg::FUNC_SUB, '0, sfma_pkg::R_MOD - 1);
    push_req(sfma_pkg::FUNC_SUB, all_ones, '0);
    push_req(sfma_pkg::FUNC_SUB, '0, all_ones);
    push_req(sfma_pkg::FUNC_MUL, '0, sfma_pkg::R_MOD - 1);
    push_req(sfma_pkg::FUNC_MUL, 256'd1, 256'd1);
    push_req(sfma_pkg::FUNC_MUL, sfma_pkg::R_MOD - 1, sfma_pkg::R_MOD - 1);
    push_req(sfma_pkg::FUNC_MUL, all_ones, all_ones);
    push_req(sfma_pkg::FUNC_MUL, sfma_pkg::R_MOD, sfma_pkg::R_MOD);
    push_req(2'd3, all_ones, all_ones);
    push_req(2'd3, '0, '0);
    wait_drained();

    // random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 34) : 0;
      for (int n = 0; n < 480; n++)
        push_req(2'($urandom_range(0, 99) < 3 ? 3 : $urandom_range(0, 2)),
                 rand_operand(), rand_operand());
      if (ph == 0) hold_off_cnt = 300;
      wait_drained();
    end

    repeat (LATENCY * 4) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
